>>> design/bprq_pkg.sv
// Shared types and constants of the bitmap priority run queue.
// Used by bprq_ctrl, bprq_dp and bitmap_priority_run_queue_core.
package bprq_pkg;

    // request codes
    localparam logic [1:0] FUNC_ENQ  = 2'd0;
    localparam logic [1:0] FUNC_DEQ  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_MISUSE = 2'd2;

    // occupancy is scanned one word per cycle
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    // field widths of the channels
    localparam int TID_W  = 6;
    localparam int PRIO_W = 8;
    localparam int CNT_W  = 7;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch request beat
        logic exec;     // update lists and counts
        logic scan;     // one occupancy word step
        logic load;     // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic misuse;     // request refused at accept
        logic need_scan;  // highest level emptied
        logic scan_done;  // new highest level found or bottom word reached
    } t_stat;

endpackage

>>> design/bprq_ctrl.sv
// Sequencer of the run queue: one request at a time through read, update
// and occupancy scan steps. Depends on bprq_pkg.
module bprq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  bprq_pkg::t_stat i_stat,
    output bprq_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RD_SLOT = 6'b000010,
        S_RD_LVL  = 6'b000100,
        S_EXEC    = 6'b001000,
        S_SCAN    = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.load   = (r_state == S_DONE) && out_free;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.misuse ? S_DONE : S_RD_SLOT;
                end
            end
            S_RD_SLOT: n_state = S_RD_LVL;
            S_RD_LVL:  n_state = S_EXEC;
            S_EXEC:    n_state = i_stat.need_scan ? S_SCAN : S_DONE;
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result beat held until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/bprq_dp.sv
// Datapath of the run queue: list memories, occupancy bits, counts,
// occupancy scanner and output register. Depends on bprq_pkg.
module bprq_dp #(
    parameter int PRIORITY_LEVELS = 256,
    parameter int THREAD_SLOTS    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bprq_pkg::t_cmd                i_cmd,
    output bprq_pkg::t_stat               o_stat,
    input  logic [1:0]                    i_func,
    input  logic [bprq_pkg::TID_W-1:0]    i_thread_id,
    input  logic [bprq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic                          i_to_head,
    input  logic                          i_bound,
    output logic [1:0]                    o_status,
    output logic [bprq_pkg::TID_W-1:0]    o_head_thread,
    output logic [bprq_pkg::PRIO_W-1:0]   o_max_priority,
    output logic [bprq_pkg::CNT_W-1:0]    o_total_count,
    output logic [bprq_pkg::CNT_W-1:0]    o_migratable_count
);

    // only levels and slots the port fields can name are stored
    localparam int LV_MAX = 1 << bprq_pkg::PRIO_W;
    localparam int SL_MAX = 1 << bprq_pkg::TID_W;
    localparam int LVN    = (PRIORITY_LEVELS < LV_MAX) ? PRIORITY_LEVELS : LV_MAX;
    localparam int SLN    = (THREAD_SLOTS < SL_MAX) ? THREAD_SLOTS : SL_MAX;
    localparam int LVW    = $clog2(LVN);
    localparam int SW     = $clog2(SLN);
    localparam int NW     = (LVN + bprq_pkg::WORD_BITS - 1) / bprq_pkg::WORD_BITS;
    localparam int WW     = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW     = bprq_pkg::WORD_SHIFT;

    // request beat
    logic [1:0]     r_func;
    logic [SW-1:0]  r_tid;
    logic [LVW-1:0] r_lvl;
    logic           r_to_head;
    logic           r_bound;
    logic [1:0]     r_status;
    logic [SW-1:0]  r_head_thr;

    // queue state
    logic [LVN-1:0]               r_occ;
    logic [SLN-1:0]               r_queued;
    logic [bprq_pkg::CNT_W-1:0]   r_total;
    logic [bprq_pkg::CNT_W-1:0]   r_unbound;
    logic [LVW-1:0]               r_highest;

    // memories and their read registers
    logic [SW-1:0]  m_head [LVN];
    logic [SW-1:0]  m_tail [LVN];
    logic [SW-1:0]  m_next [SLN];
    logic [SW-1:0]  m_prev [SLN];
    logic [LVW-1:0] m_slvl [SLN];
    logic           m_sbnd [SLN];
    logic [SW-1:0]  r_rd_head, r_rd_tail, r_rd_next, r_rd_prev;
    logic [LVW-1:0] r_rd_slvl;
    logic           r_rd_sbnd;

    // scanner
    logic [WW-1:0]  r_word;
    logic [BW-1:0]  r_bitpos;
    logic           r_first;

    logic [NW*bprq_pkg::WORD_BITS-1:0] occ_pad;
    logic [bprq_pkg::WORD_BITS-1:0]    scan_word;
    logic [bprq_pkg::WORD_BITS-1:0]    scan_mask;
    logic                              found;
    logic [BW-1:0]                     found_pos;

    logic [SW-1:0]  in_tid;
    logic           tid_bad, queued_in, misuse_in, empty_now;
    logic [LVW-1:0] a_lvl;
    logic           only_one, is_head, is_tail, lvl_occ;

    assign in_tid    = i_thread_id[SW-1:0];
    assign tid_bad   = 32'(i_thread_id) >= THREAD_SLOTS;
    assign queued_in = !tid_bad && r_queued[in_tid];
    assign empty_now = (r_total == '0) || !r_occ[r_highest];

    // refusal decided on the request beat itself
    always_comb begin
        unique case (i_func)
            bprq_pkg::FUNC_ENQ:
                misuse_in = tid_bad || (32'(i_priority_req) >= PRIORITY_LEVELS) || queued_in;
            bprq_pkg::FUNC_DEQ:  misuse_in = tid_bad || !queued_in;
            bprq_pkg::FUNC_PEEK: misuse_in = 1'b0;
            default:             misuse_in = 1'b1;
        endcase
    end

    // level address: recorded level for dequeue
    assign a_lvl    = (r_func == bprq_pkg::FUNC_DEQ) ? r_rd_slvl : r_lvl;
    assign lvl_occ  = r_occ[a_lvl];
    assign is_head  = (r_rd_head == r_tid);
    assign is_tail  = (r_rd_tail == r_tid);
    assign only_one = is_head && is_tail;

    // occupancy word under the scanner, bits above start masked off
    always_comb begin
        occ_pad   = '0;
        occ_pad[LVN-1:0] = r_occ;
        scan_word = occ_pad[r_word*bprq_pkg::WORD_BITS +: bprq_pkg::WORD_BITS];
        scan_mask = r_first ? ({bprq_pkg::WORD_BITS{1'b1}} >> (BW'(bprq_pkg::WORD_BITS - 1) - r_bitpos))
                            : {bprq_pkg::WORD_BITS{1'b1}};
        found     = 1'b0;
        found_pos = '0;
        for (int i = 0; i < bprq_pkg::WORD_BITS; i++) begin
            if (scan_word[i] && scan_mask[i]) begin
                found     = 1'b1;
                found_pos = BW'(i);
            end
        end
    end

    assign o_stat.misuse    = misuse_in;
    assign o_stat.need_scan = (r_func == bprq_pkg::FUNC_DEQ) && only_one && (a_lvl == r_highest);
    assign o_stat.scan_done = found || (r_word == '0);

    // memory reads every cycle at the current addresses
    always_ff @(posedge i_clk) begin
        r_rd_next <= m_next[r_tid];
        r_rd_prev <= m_prev[r_tid];
        r_rd_slvl <= m_slvl[r_tid];
        r_rd_sbnd <= m_sbnd[r_tid];
        r_rd_head <= m_head[a_lvl];
        r_rd_tail <= m_tail[a_lvl];
    end

    // list memory writes, at most one per memory per request
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_func == bprq_pkg::FUNC_ENQ) begin
                m_slvl[r_tid] <= r_lvl;
                m_sbnd[r_tid] <= r_bound;
                if (!lvl_occ) begin
                    m_head[r_lvl] <= r_tid;
                    m_tail[r_lvl] <= r_tid;
                end else if (r_to_head) begin
                    m_next[r_tid]     <= r_rd_head;
                    m_prev[r_rd_head] <= r_tid;
                    m_head[r_lvl]     <= r_tid;
                end else begin
                    m_prev[r_tid]     <= r_rd_tail;
                    m_next[r_rd_tail] <= r_tid;
                    m_tail[r_lvl]     <= r_tid;
                end
            end else if (r_func == bprq_pkg::FUNC_DEQ) begin
                if (only_one) begin
                end else if (is_head) begin
                    m_head[a_lvl] <= r_rd_next;
                end else if (is_tail) begin
                    m_tail[a_lvl] <= r_rd_prev;
                end else begin
                    m_next[r_rd_prev] <= r_rd_next;
                    m_prev[r_rd_next] <= r_rd_prev;
                end
            end
        end
    end

    // request beat capture and peek head
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func     <= i_func;
            r_tid      <= in_tid;
            r_lvl      <= (i_func == bprq_pkg::FUNC_PEEK) ? r_highest : LVW'(i_priority_req);
            r_to_head  <= i_to_head;
            r_bound    <= i_bound;
            r_head_thr <= '0;
            if (misuse_in) begin
                r_status <= bprq_pkg::ST_MISUSE;
            end else if (i_func == bprq_pkg::FUNC_PEEK && empty_now) begin
                r_status <= bprq_pkg::ST_EMPTY;
            end else begin
                r_status <= bprq_pkg::ST_OK;
            end
        end else if (i_cmd.exec) begin
            if (r_func == bprq_pkg::FUNC_PEEK && r_status == bprq_pkg::ST_OK) begin
                r_head_thr <= r_rd_head;
            end
        end
    end

    // scanner position
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_word   <= WW'(a_lvl >> BW);
            r_bitpos <= a_lvl[BW-1:0];
            r_first  <= 1'b1;
        end else if (i_cmd.scan) begin
            r_word   <= r_word - 1'b1;
            r_first  <= 1'b0;
        end
    end

    // occupancy, queued flags, counts, highest level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_queued  <= '0;
            r_total   <= '0;
            r_unbound <= '0;
            r_highest <= '0;
        end else if (i_cmd.exec) begin
            if (r_func == bprq_pkg::FUNC_ENQ) begin
                r_occ[r_lvl]    <= 1'b1;
                r_queued[r_tid] <= 1'b1;
                r_total         <= r_total + 1'b1;
                if (!r_bound) begin
                    r_unbound <= r_unbound + 1'b1;
                end
                if (r_lvl > r_highest) begin
                    r_highest <= r_lvl;
                end
            end else if (r_func == bprq_pkg::FUNC_DEQ) begin
                r_queued[r_tid] <= 1'b0;
                if (r_total != '0) begin
                    r_total <= r_total - 1'b1;
                end
                if (!r_rd_sbnd && r_unbound != '0) begin
                    r_unbound <= r_unbound - 1'b1;
                end
                if (only_one) begin
                    r_occ[a_lvl] <= 1'b0;
                end
            end
        end else if (i_cmd.scan) begin
            if (found) begin
                r_highest <= LVW'({r_word, found_pos});
            end else if (r_word == '0) begin
                r_highest <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_status           <= r_status;
            o_head_thread      <= bprq_pkg::TID_W'(r_head_thr);
            o_max_priority     <= bprq_pkg::PRIO_W'(r_highest);
            o_total_count      <= r_total;
            o_migratable_count <= r_unbound;
        end
    end

endmodule

>>> design/bitmap_priority_run_queue_core.sv
// Top level of the bitmap priority run queue.
// Depends on bprq_pkg, bprq_ctrl and bprq_dp.
//
// Request channel (i_in_valid / o_in_ready) carries one beat: func, thread
// slot, priority level, head-insert flag and bound flag. Enqueue, dequeue
// and peek each give exactly one result beat on the result channel
// (o_out_valid / i_out_ready): status, peeked head, highest occupied
// level and the total and migratable counts after the request.
// For a normal request the memory read sequence (slot record, then level
// head/tail) comes before the update; a refused request goes straight to
// the result. A dequeue that empties the highest level then scans the
// 32-level occupancy words downwards, one word per cycle (at most 8).
// The next request is taken in the cycle after the result is loaded.
// One request is worked on at a time; a new request is taken while the
// previous result still waits in the output register.
// Reset (synchronous, active low) empties every level and clears the
// counts at once; list memories need no clearing pass.
// If the receiver stalls, the result holds and the block stops accepting
// once the next result is ready.
module bitmap_priority_run_queue_core #(
    parameter int PRIORITY_LEVELS = 256,
    parameter int THREAD_SLOTS    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_func,
    input  logic [bprq_pkg::TID_W-1:0]    i_thread_id,
    input  logic [bprq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic                          i_to_head,
    input  logic                          i_bound,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [bprq_pkg::TID_W-1:0]    o_head_thread,
    output logic [bprq_pkg::PRIO_W-1:0]   o_max_priority,
    output logic [bprq_pkg::CNT_W-1:0]    o_total_count,
    output logic [bprq_pkg::CNT_W-1:0]    o_migratable_count
);

    bprq_pkg::t_cmd  cmd;
    bprq_pkg::t_stat stat;

    // sequencer
    bprq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // lists, bitmap and counts
    bprq_dp #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .THREAD_SLOTS    (THREAD_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_func             (i_func),
        .i_thread_id        (i_thread_id),
        .i_priority_req     (i_priority_req),
        .i_to_head          (i_to_head),
        .i_bound            (i_bound),
        .o_status           (o_status),
        .o_head_thread      (o_head_thread),
        .o_max_priority     (o_max_priority),
        .o_total_count      (o_total_count),
        .o_migratable_count (o_migratable_count)
    );

endmodule

>>> sim/tb_bitmap_priority_run_queue_core.sv
// Testbench of the bitmap priority run queue core: directed and random requests.
// Depends on bprq_pkg and bitmap_priority_run_queue_core; a built-in queue model predicts each result.
`timescale 1ns / 1ps

module tb_bitmap_priority_run_queue_core;

    localparam int LEVELS = 256;
    localparam int SLOTS  = 64;

    // request code with no meaning
    localparam logic [1:0] FUNC_UNDEF = 2'd3;

    typedef struct packed {
        logic [1:0]                  status;
        logic [bprq_pkg::TID_W-1:0]  head;
        logic [bprq_pkg::PRIO_W-1:0] maxp;
        logic [bprq_pkg::CNT_W-1:0]  total;
        logic [bprq_pkg::CNT_W-1:0]  unbound;
    } t_result;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    logic [1:0] i_func;
    logic [bprq_pkg::TID_W-1:0] i_thread_id;
    logic [bprq_pkg::PRIO_W-1:0] i_priority_req;
    logic i_to_head, i_bound;
    logic o_out_valid, i_out_ready;
    logic [1:0] o_status;
    logic [bprq_pkg::TID_W-1:0] o_head_thread;
    logic [bprq_pkg::PRIO_W-1:0] o_max_priority;
    logic [bprq_pkg::CNT_W-1:0] o_total_count, o_migratable_count;

    bitmap_priority_run_queue_core dut (.*);

    // shadow of the run queue
    bit                          lvl_occ  [LEVELS];
    logic [bprq_pkg::TID_W-1:0]  lvl_head [LEVELS];
    logic [bprq_pkg::TID_W-1:0]  lvl_tail [LEVELS];
    logic [bprq_pkg::TID_W-1:0]  nxt      [SLOTS];
    logic [bprq_pkg::TID_W-1:0]  prv      [SLOTS];
    bit                          queued   [SLOTS];
    logic [bprq_pkg::PRIO_W-1:0] slot_lvl [SLOTS];
    bit                          slot_pin [SLOTS];
    int unsigned                 n_total, n_unbound, top_lvl;

    t_result pending_results[$];
    int      errors;
    bit      hold_off;

    // predict the result of one request and update the shadow
    function automatic t_result run_queue_step(logic [1:0] f, logic [bprq_pkg::TID_W-1:0] t,
                                              logic [bprq_pkg::PRIO_W-1:0] l, bit hd, bit pin);
        t_result r;
        int lv;
        r = '0;
        r.status = bprq_pkg::ST_OK;
        if (f == bprq_pkg::FUNC_ENQ) begin
            if (queued[t]) begin
                r.status = bprq_pkg::ST_MISUSE;
            end else begin
                if (!lvl_occ[l]) begin
                    lvl_occ[l] = 1; lvl_head[l] = t; lvl_tail[l] = t;
                end else if (hd) begin
                    nxt[t] = lvl_head[l]; prv[lvl_head[l]] = t; lvl_head[l] = t;
                end else begin
                    prv[t] = lvl_tail[l]; nxt[lvl_tail[l]] = t; lvl_tail[l] = t;
                end
                queued[t] = 1; slot_lvl[t] = l; slot_pin[t] = pin;
                n_total++;
                if (!pin) n_unbound++;
                if (l > top_lvl) top_lvl = l;
            end
        end else if (f == bprq_pkg::FUNC_DEQ) begin
            if (!queued[t]) begin
                r.status = bprq_pkg::ST_MISUSE;
            end else begin
                lv = slot_lvl[t];
                queued[t] = 0;
                if (n_total > 0) n_total--;
                if (!slot_pin[t] && n_unbound > 0) n_unbound--;
                if (lvl_head[lv] == t && lvl_tail[lv] == t) begin
                    lvl_occ[lv] = 0;
                    if (lv == top_lvl) begin
                        top_lvl = 0;
                        for (int i = lv - 1; i >= 0; i--)
                            if (lvl_occ[i]) begin top_lvl = i; break; end
                    end
                end else if (lvl_head[lv] == t) begin
                    lvl_head[lv] = nxt[t];
                end else if (lvl_tail[lv] == t) begin
                    lvl_tail[lv] = prv[t];
                end else begin
                    nxt[prv[t]] = nxt[t]; prv[nxt[t]] = prv[t];
                end
            end
        end else if (f == bprq_pkg::FUNC_PEEK) begin
            if (n_total == 0 || !lvl_occ[top_lvl]) r.status = bprq_pkg::ST_EMPTY;
            else r.head = lvl_head[top_lvl];
        end else begin
            r.status = bprq_pkg::ST_MISUSE;
        end
        r.maxp    = bprq_pkg::PRIO_W'(top_lvl);
        r.total   = bprq_pkg::CNT_W'(n_total);
        r.unbound = bprq_pkg::CNT_W'(n_unbound);
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // send one request beat after a random gap
    task automatic send_request(logic [1:0] f, logic [bprq_pkg::TID_W-1:0] t,
                                logic [bprq_pkg::PRIO_W-1:0] l, bit hd, bit pin);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        repeat (gap) @(negedge i_clk);
        i_in_valid = 1; i_func = f; i_thread_id = t;
        i_priority_req = l; i_to_head = hd; i_bound = pin;
        // ready is settled at the falling edge; the next rising edge takes the beat
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        pending_results.push_back(run_queue_step(f, t, l, hd, pin));
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    // receiver: random stall per beat, long hold-off on request
    initial begin
        int stall;
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready = 0;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                i_out_ready = 0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1;
            // hold ready until one result beat is taken
            while (!o_out_valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, o_status);
                    errors++;
                end
                if (o_head_thread !== exp_r.head) begin
                    $display("%0t: head exp %0d got %0d", $time, exp_r.head, o_head_thread);
                    errors++;
                end
                if (o_max_priority !== exp_r.maxp) begin
                    $display("%0t: max_priority exp %0d got %0d", $time, exp_r.maxp,
                             o_max_priority);
                    errors++;
                end
                if (o_total_count !== exp_r.total) begin
                    $display("%0t: total exp %0d got %0d", $time, exp_r.total, o_total_count);
                    errors++;
                end
                if (o_migratable_count !== exp_r.unbound) begin
                    $display("%0t: migratable exp %0d got %0d", $time, exp_r.unbound,
                             o_migratable_count);
                    errors++;
                end
            end
        end
    end

    // pick a slot that is queued (or any slot if none)
    function automatic logic [bprq_pkg::TID_W-1:0] pick_queued();
        int t;
        t = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
            if (queued[(t + i) % SLOTS]) return bprq_pkg::TID_W'((t + i) % SLOTS);
        return bprq_pkg::TID_W'(t);
    endfunction

    function automatic logic [bprq_pkg::TID_W-1:0] pick_free();
        int t;
        t = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
            if (!queued[(t + i) % SLOTS]) return bprq_pkg::TID_W'((t + i) % SLOTS);
        return bprq_pkg::TID_W'(t);
    endfunction

    // extremes, every code and each refusal
    task automatic test_directed();
        send_request(bprq_pkg::FUNC_PEEK, 0, 0, 0, 0);
        send_request(bprq_pkg::FUNC_DEQ, 5, 0, 0, 0);
        send_request(bprq_pkg::FUNC_ENQ, 63, 255, 1, 1);
        send_request(bprq_pkg::FUNC_ENQ, 63, 10, 0, 0);
        send_request(bprq_pkg::FUNC_ENQ, 0, 0, 0, 0);
        send_request(bprq_pkg::FUNC_ENQ, 1, 255, 0, 0);
        send_request(bprq_pkg::FUNC_ENQ, 2, 255, 1, 1);
        send_request(bprq_pkg::FUNC_ENQ, 3, 255, 0, 0);
        send_request(bprq_pkg::FUNC_PEEK, 42, 7, 1, 1);
        send_request(bprq_pkg::FUNC_DEQ, 1, 0, 1, 1);
        send_request(bprq_pkg::FUNC_DEQ, 2, 3, 0, 1);
        send_request(FUNC_UNDEF, 7, 100, 1, 1);
        send_request(bprq_pkg::FUNC_PEEK, 0, 0, 0, 0);
        send_request(bprq_pkg::FUNC_DEQ, 63, 0, 0, 0);
        send_request(bprq_pkg::FUNC_DEQ, 3, 0, 0, 0);
        send_request(bprq_pkg::FUNC_PEEK, 0, 0, 0, 0);
        send_request(bprq_pkg::FUNC_DEQ, 0, 0, 0, 0);
        send_request(bprq_pkg::FUNC_PEEK, 0, 0, 0, 0);
        send_request(bprq_pkg::FUNC_DEQ, 0, 0, 0, 0);
    endtask

    // random mixes, mostly well-formed
    task automatic test_random(int count);
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 45)
                send_request(bprq_pkg::FUNC_ENQ, pick_free(),
                             bprq_pkg::PRIO_W'($urandom_range(0, 3) == 0
                                               ? $urandom_range(0, 255)
                                               : $urandom_range(0, 15)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (k < 80)
                send_request(bprq_pkg::FUNC_DEQ, pick_queued(),
                             bprq_pkg::PRIO_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (k < 92)
                send_request(bprq_pkg::FUNC_PEEK, bprq_pkg::TID_W'($urandom_range(0, 63)),
                             bprq_pkg::PRIO_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_request(2'($urandom_range(0, 3)), bprq_pkg::TID_W'($urandom_range(0, 63)),
                             bprq_pkg::PRIO_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // fill to the brim, then drain everything
    task automatic test_fill_drain();
        for (int i = 0; i < SLOTS; i++)
            send_request(bprq_pkg::FUNC_ENQ, bprq_pkg::TID_W'(i),
                         bprq_pkg::PRIO_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_request(bprq_pkg::FUNC_ENQ, bprq_pkg::TID_W'($urandom_range(0, 63)), 0, 0, 0);
        send_request(bprq_pkg::FUNC_PEEK, 0, 0, 0, 0);
        for (int i = 0; i < SLOTS; i++)
            send_request(bprq_pkg::FUNC_DEQ, pick_queued(), 0, 0, 0);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_off = 1;
        test_random(40);
    endtask

    initial begin
        errors = 0; hold_off = 0;
        i_in_valid = 0; i_func = bprq_pkg::FUNC_PEEK; i_thread_id = 0;
        i_priority_req = 0; i_to_head = 0; i_bound = 0;
        lvl_occ = '{default: 0}; queued = '{default: 0};
        n_total = 0; n_unbound = 0; top_lvl = 0;
        i_rst_n = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_fill_drain();
        test_backpressure();
        test_random(1400);
        wait (pending_results.size() == 0);
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("tb_bitmap_priority_run_queue_core OK");
        else
            $display("tb_bitmap_priority_run_queue_core NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb_bitmap_priority_run_queue_core NOT OK");
        $finish;
    end

endmodule

>>> sim.f
design/bprq_pkg.sv
design/bprq_ctrl.sv
design/bprq_dp.sv
design/bitmap_priority_run_queue_core.sv
sim/tb_bitmap_priority_run_queue_core.sv
